// File: sv/variable_rate_adpcm_decoder_unit_defines.svh
// Assertion macros used by the decoder's checker file.
`ifndef VARIABLE_RATE_ADPCM_DECODER_UNIT_DEFINES_SVH
`define VARIABLE_RATE_ADPCM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VRAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define VRAD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/vrad_pkg.sv
// Shared constants, types and the IMA step table of the ADPCM decoder.
package vrad_pkg;

  localparam int STEP_TABLE_ENTRIES_DEF = 80;
  localparam int IMA_TABLE_DEPTH        = 89;
  localparam int TWO_BIT_LIMIT          = 18;

  localparam int CODE_W   = 8;
  localparam int INDEX_W  = 7;
  localparam int STEP_W   = 15;
  localparam int PRED_W   = 12;
  localparam int SAMPLE_W = 16;
  localparam int BITPOS_W = 4;

  localparam logic signed [PRED_W-1:0] PRED_MIN = -12'sd2048;
  localparam logic signed [PRED_W-1:0] PRED_MAX = 12'sd2047;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch a new byte beat
    logic step;   // decode one code and register its sample
  } vrad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;   // the code decoded this cycle uses up the byte
  } vrad_sts_t;

  function automatic logic [STEP_W-1:0] ima_step(input logic [INDEX_W-1:0] idx);
    logic [STEP_W-1:0] v;
    case (idx)
      7'd0:  v = 15'd7;     7'd1:  v = 15'd8;     7'd2:  v = 15'd9;
      7'd3:  v = 15'd10;    7'd4:  v = 15'd11;    7'd5:  v = 15'd12;
      7'd6:  v = 15'd13;    7'd7:  v = 15'd14;    7'd8:  v = 15'd16;
      7'd9:  v = 15'd17;    7'd10: v = 15'd19;    7'd11: v = 15'd21;
      7'd12: v = 15'd23;    7'd13: v = 15'd25;    7'd14: v = 15'd28;
      7'd15: v = 15'd31;    7'd16: v = 15'd34;    7'd17: v = 15'd37;
      7'd18: v = 15'd41;    7'd19: v = 15'd45;    7'd20: v = 15'd50;
      7'd21: v = 15'd55;    7'd22: v = 15'd60;    7'd23: v = 15'd66;
      7'd24: v = 15'd73;    7'd25: v = 15'd80;    7'd26: v = 15'd88;
      7'd27: v = 15'd97;    7'd28: v = 15'd107;   7'd29: v = 15'd118;
      7'd30: v = 15'd130;   7'd31: v = 15'd143;   7'd32: v = 15'd157;
      7'd33: v = 15'd173;   7'd34: v = 15'd190;   7'd35: v = 15'd209;
      7'd36: v = 15'd230;   7'd37: v = 15'd253;   7'd38: v = 15'd279;
      7'd39: v = 15'd307;   7'd40: v = 15'd337;   7'd41: v = 15'd371;
      7'd42: v = 15'd408;   7'd43: v = 15'd449;   7'd44: v = 15'd494;
      7'd45: v = 15'd544;   7'd46: v = 15'd598;   7'd47: v = 15'd658;
      7'd48: v = 15'd724;   7'd49: v = 15'd796;   7'd50: v = 15'd876;
      7'd51: v = 15'd963;   7'd52: v = 15'd1060;  7'd53: v = 15'd1166;
      7'd54: v = 15'd1282;  7'd55: v = 15'd1411;  7'd56: v = 15'd1552;
      7'd57: v = 15'd1707;  7'd58: v = 15'd1878;  7'd59: v = 15'd2066;
      7'd60: v = 15'd2272;  7'd61: v = 15'd2499;  7'd62: v = 15'd2749;
      7'd63: v = 15'd3024;  7'd64: v = 15'd3327;  7'd65: v = 15'd3660;
      7'd66: v = 15'd4026;  7'd67: v = 15'd4428;  7'd68: v = 15'd4871;
      7'd69: v = 15'd5358;  7'd70: v = 15'd5894;  7'd71: v = 15'd6484;
      7'd72: v = 15'd7132;  7'd73: v = 15'd7845;  7'd74: v = 15'd8630;
      7'd75: v = 15'd9493;  7'd76: v = 15'd10442; 7'd77: v = 15'd11487;
      7'd78: v = 15'd12635; 7'd79: v = 15'd13899; 7'd80: v = 15'd15289;
      7'd81: v = 15'd16818; 7'd82: v = 15'd18500; 7'd83: v = 15'd20350;
      7'd84: v = 15'd22385; 7'd85: v = 15'd24623; 7'd86: v = 15'd27086;
      7'd87: v = 15'd29794;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

endpackage

// File: sv/vrad_ifs.sv
// Valid/ready channel interfaces for the decoder's byte input and sample output.
interface vrad_in_if import vrad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  code_byte;
  logic               track_start;
  logic [INDEX_W-1:0] start_step_index;
  logic               track_end;

  modport source (output valid, code_byte, track_start, start_step_index, track_end,
                  input ready);
  modport sink   (input valid, code_byte, track_start, start_step_index, track_end,
                  output ready);
  modport monitor (input valid, ready, code_byte, track_start, start_step_index,
                   track_end);
endinterface

interface vrad_out_if import vrad_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pcm_sample;
  logic                       last_of_byte;
  logic                       last_of_track;

  modport source (output valid, pcm_sample, last_of_byte, last_of_track, input ready);
  modport sink   (input valid, pcm_sample, last_of_byte, last_of_track, output ready);
  modport monitor (input valid, ready, pcm_sample, last_of_byte, last_of_track);
endinterface

// File: sv/vrad_ctrl.sv
// Controller state machine: byte acceptance, code sequencing and output valid.
module vrad_ctrl import vrad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vrad_sts_t sts,
  output vrad_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // A code is decoded only when the output register is free this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.step      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/vrad_datapath.sv
// Datapath: code extraction, step table lookup, predictor update and sample register.
module vrad_datapath import vrad_pkg::*; #(
  parameter int STEP_TABLE_ENTRIES = STEP_TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vrad_cmd_t                  cmd,
  output vrad_sts_t                  sts,
  input  logic [CODE_W-1:0]          code_byte,
  input  logic                       track_start,
  input  logic [INDEX_W-1:0]         start_step_index,
  input  logic                       track_end,
  output logic signed [SAMPLE_W-1:0] pcm_sample,
  output logic                       last_of_byte,
  output logic                       last_of_track
);

  localparam logic [INDEX_W-1:0] MAX_POS = INDEX_W'(STEP_TABLE_ENTRIES - 1);
  localparam int MAG_W = STEP_W + 2;
  localparam int SUM_W = MAG_W + 2;

  logic [CODE_W-1:0]        bits_r, bits_nxt;
  logic [BITPOS_W-1:0]      bitpos_r, bitpos_nxt;
  logic                     end_r;
  logic signed [PRED_W-1:0] pred_r, pred_nxt;
  logic [INDEX_W-1:0]       step_pos_r, step_pos_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                     last_byte_r, last_track_r;

  logic [STEP_W-1:0]        step;
  logic                     use4;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic signed [4:0]        adj;
  logic signed [INDEX_W+1:0] newpos;
  logic signed [MAG_W:0]    diff;
  logic signed [SUM_W-1:0]  sum;
  logic [INDEX_W-1:0]       start_clamped;

  assign step = ima_step(step_pos_r);
  // Four-bit codes need a large enough step and at least four unread bits.
  assign use4 = (step_pos_r >= INDEX_W'(TWO_BIT_LIMIT)) && (bitpos_r <= BITPOS_W'(4));

  always_comb begin
    mag = MAG_W'(step >> 3);
    if (use4) begin
      if (bits_r[0]) mag = mag + MAG_W'(step >> 2);
      if (bits_r[1]) mag = mag + MAG_W'(step >> 1);
      if (bits_r[2]) mag = mag + MAG_W'(step);
      neg = bits_r[3];
      adj = bits_r[2] ? signed'({2'b00, bits_r[1:0], 1'b0}) + 5'sd2 : -5'sd1;
      bits_nxt   = bits_r >> 4;
      bitpos_nxt = bitpos_r + BITPOS_W'(4);
    end else begin
      if (bits_r[0]) mag = mag + MAG_W'(step);
      neg = bits_r[1];
      adj = bits_r[0] ? 5'sd2 : -5'sd1;
      bits_nxt   = bits_r >> 2;
      bitpos_nxt = bitpos_r + BITPOS_W'(2);
    end

    newpos = signed'({2'b00, step_pos_r}) + (INDEX_W+2)'(adj);
    if (newpos < 0) begin
      step_pos_nxt = '0;
    end else if (newpos > signed'({2'b00, MAX_POS})) begin
      step_pos_nxt = MAX_POS;
    end else begin
      step_pos_nxt = newpos[INDEX_W-1:0];
    end

    diff = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    sum  = SUM_W'(pred_r) + SUM_W'(diff);
    if (sum < SUM_W'(PRED_MIN)) begin
      pred_nxt = PRED_MIN;
    end else if (sum > SUM_W'(PRED_MAX)) begin
      pred_nxt = PRED_MAX;
    end else begin
      pred_nxt = sum[PRED_W-1:0];
    end
  end

  assign start_clamped = (start_step_index > MAX_POS) ? MAX_POS : start_step_index;
  assign sts.last      = bitpos_nxt[BITPOS_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r     <= '0;
      step_pos_r <= '0;
    end else if (cmd.load) begin
      if (track_start) begin
        pred_r     <= '0;
        step_pos_r <= start_clamped;
      end
    end else if (cmd.step) begin
      pred_r     <= pred_nxt;
      step_pos_r <= step_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bits_r   <= code_byte;
      bitpos_r <= '0;
      end_r    <= track_end;
    end else if (cmd.step) begin
      bits_r   <= bits_nxt;
      bitpos_r <= bitpos_nxt;
    end
    if (cmd.step) begin
      sample_r     <= {pred_nxt, 4'b0000};
      last_byte_r  <= sts.last;
      last_track_r <= sts.last && end_r;
    end
  end

  assign pcm_sample    = sample_r;
  assign last_of_byte  = last_byte_r;
  assign last_of_track = last_track_r;

endmodule

// File: sv/variable_rate_adpcm_decoder_unit.sv
// A byte beat is accepted while the controller is idle; its first sample is registered by the
// first decode step. Each byte decodes into two to four samples, one per cycle while the output
// is not stalled, because every code depends on the step index and predictor left by the code
// before it (step table plus predictor adder loop). No byte is accepted while one is decoding.
// Reset is synchronous and active low; it clears the predictor, the step index and output valid.
module variable_rate_adpcm_decoder_unit import vrad_pkg::*; #(
  parameter int STEP_TABLE_ENTRIES = STEP_TABLE_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vrad_in_if.sink   in_ch,
  vrad_out_if.source out_ch
);

  // Commands and status between the sequencing controller and the datapath.
  vrad_cmd_t cmd;
  vrad_sts_t sts;

  // The controller accepts a byte beat whenever it is idle, even while the
  // last sample of the previous byte still waits in the output register.
  // It then issues one decode step per cycle in which the output register
  // is empty or being drained, until the datapath reports the byte used up.
  vrad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the byte being decoded, the predictor and step index,
  // and the registered output sample with its end-of-byte and end-of-track flags.
  vrad_datapath #(
    .STEP_TABLE_ENTRIES (STEP_TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .code_byte        (in_ch.code_byte),
    .track_start      (in_ch.track_start),
    .start_step_index (in_ch.start_step_index),
    .track_end        (in_ch.track_end),
    .pcm_sample       (out_ch.pcm_sample),
    .last_of_byte     (out_ch.last_of_byte),
    .last_of_track    (out_ch.last_of_track)
  );

endmodule

// File: sv/vrad_checker.sv
// Port-level assertions for the decoder, bound to the top level.
`include "variable_rate_adpcm_decoder_unit_defines.svh"

module vrad_checker import vrad_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_pcm_sample,
  input logic                       out_last_of_byte,
  input logic                       out_last_of_track
);

  `VRAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pcm_sample), "stalled sample beat changed")
  `VRAD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid, "sample beat valid right after reset")
  `VRAD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "byte beat accepted while previous byte still decoding")
  `VRAD_ASSERT_IMPLY(a_track_implies_byte, clk, rst_n, out_valid && out_last_of_track, out_last_of_byte, "end of track flagged on a sample that does not end its byte")

endmodule

bind variable_rate_adpcm_decoder_unit vrad_checker u_vrad_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_pcm_sample    (out_ch.pcm_sample),
  .out_last_of_byte  (out_ch.last_of_byte),
  .out_last_of_track (out_ch.last_of_track)
);
